// ===== sv/gte_pkg.sv =====
// Shared types and constants for the Goertzel THD estimator.
// No dependencies; imported by every module of the block.
package gte_pkg;

	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int GFRAC = 8;
	localparam int MIN_SAMPLES = 8;
	localparam int COEF_W = 32;
	localparam int THD_W = 24;
	localparam int STAT_W = 2;
	localparam int ACC_W = 64;
	localparam int EX_W = 8;
	localparam int EX_INIT = 32 + 2 * GFRAC - 1;
	localparam int DIV_STEPS = 64;
	localparam int SQRT_STEPS = 32;
	localparam int STEP_W = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_COS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN = 1'b1;

	localparam logic [COEF_W-1:0] COS_RESET = 32'h4000_0000;
	localparam logic [COEF_W-1:0] SIN_RESET = 32'h0000_0000;

	// floor((2^64 - 1) / 10000)
	localparam logic [ACC_W-1:0] X_LIMIT = 64'd1844674407370955;
	localparam logic [13:0] XM_SCALE = 14'd10000;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_SHORT  = 2'd1,
		STAT_ZERO   = 2'd2,
		STAT_NOFUND = 2'd3
	} gte_stat_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_TAKE, OP_LD_PC, OP_LD_P2C, OP_LD_P2S, OP_MLO, OP_MHI, OP_MSAT,
		OP_SUPD, OP_FRE, OP_FIM, OP_STAT, OP_NORM, OP_SQA, OP_SQB, OP_EN, OP_ENADJ,
		OP_DINIT, OP_DSTEP, OP_DEXT, OP_DSHR, OP_X, OP_XM, OP_SQRT, OP_THD, OP_OUT
	} gte_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SLD, ST_MLO, ST_MHI, ST_MSAT, ST_SUPD, ST_FCHK, ST_FLDC, ST_FRE,
		ST_FLDS, ST_FIM, ST_FZ, ST_FSTAT, ST_NORM, ST_SQA, ST_SQB, ST_EN, ST_ENADJ,
		ST_DINIT, ST_DIV, ST_DEXT, ST_XCHK, ST_XM, ST_SQRT, ST_THD, ST_DONE
	} gte_state_t;

	typedef enum logic [1:0] {
		PH_SAMPLE, PH_RE, PH_IM
	} gte_phase_t;

	typedef struct packed {
		gte_op_t op;
	} gte_cmd_t;

	typedef struct packed {
		logic full;
		logic last;
		logic cnt_lt8;
		logic e_zero;
		logic mag_zero;
		logic norm_done;
		logic en_ovf;
		logic ex_neg;
		logic ex_zero;
		logic q_small;
		logic x_big;
	} gte_sts_t;

endpackage

// ===== sv/gte_datapath.sv =====
// Datapath: coefficient registers, record state, shared 32x32 product unit,
// normalise, long division and square-root iterations. Uses gte_pkg.
module gte_datapath import gte_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gte_cmd_t               cmd,
	output gte_sts_t               sts,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [COEF_W-1:0]      cfg_data,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last_sample,
	output logic [THD_W-1:0]       thd_pct,
	output logic [STAT_W-1:0]      status
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam int EN_W = SQ_W + CNT_W;
	localparam int PR_W = (EN_W + CNT_W > ACC_W + 1) ? EN_W + CNT_W : ACC_W + 1;
	localparam logic signed [65:0] SLIM = 66'sd1 <<< 61;

	function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] v);
		mag64 = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
	endfunction

	logic [COEF_W-1:0] cos_q, sin_q;
	logic signed [ACC_W-1:0] prev_q, prev2_q;
	logic [EN_W-1:0] energy_q;
	logic [CNT_W-1:0] count_q;

	logic signed [SAMPLE_BITS-1:0] xs_q;
	logic last_q;
	logic [SQ_W-1:0] sq_q;
	logic [61:0] ma_q;
	logic [31:0] mb_q;
	logic neg_q, sh29_q;
	logic [63:0] plo_q;
	logic [61:0] phi_q;
	logic signed [ACC_W-1:0] mres_q;
	logic [ACC_W-1:0] ar_q, ai_q, sqa_q, m2_q;
	logic signed [EX_W-1:0] ex_q;
	logic [EN_W-1:0] e_q;
	logic [PR_W-1:0] en_q;
	logic [ACC_W-1:0] num_q, rem_q, quo_q, x_q, y_q, r_q, bit_q;
	logic [THD_W-1:0] thd_q, thd_out_q;
	logic [STAT_W-1:0] stat_q, stat_out_q;

	logic signed [SQ_W-1:0] sq_prod;
	logic [63:0] plo_prod;
	logic [61:0] phi_prod;
	logic [65:0] p_sum;
	logic [61:0] p_cap;
	logic signed [65:0] s_sum;
	logic signed [ACC_W-1:0] s_sat;
	logic signed [64:0] re_sum;
	logic [61:0] sqa_prod, sqb_prod;
	logic [PR_W-1:0] en_prod;
	logic din;
	logic [ACC_W-1:0] rem2;
	logic dge;
	logic [ACC_W-1:0] x_val;
	logic [ACC_W-1:0] xm_prod;
	logic [64:0] rt_sum;
	logic rt_ge;
	logic signed [ACC_W-1:0] ld_s;
	logic [COEF_W-1:0] ld_c;
	logic [ACC_W-1:0] ld_mag;

	assign sq_prod  = xs_q * xs_q;
	assign plo_prod = ma_q[31:0] * mb_q;
	assign phi_prod = ma_q[61:32] * mb_q;
	assign p_sum    = (66'(phi_q) << (sh29_q ? 3 : 2))
		+ 66'(sh29_q ? (plo_q >> 29) : (plo_q >> 30));
	assign p_cap    = (p_sum > 66'(SLIM)) ? 62'(SLIM) : p_sum[61:0];
	assign s_sum    = (66'(xs_q) <<< GFRAC) + 66'(mres_q) - 66'(prev2_q);
	assign s_sat    = (s_sum > SLIM) ? ACC_W'(SLIM)
		: (s_sum < -SLIM) ? ACC_W'(-SLIM) : ACC_W'(s_sum);
	assign re_sum   = 65'(prev_q) - 65'(mres_q);
	assign sqa_prod = ar_q[30:0] * ar_q[30:0];
	assign sqb_prod = ai_q[30:0] * ai_q[30:0];
	assign en_prod  = e_q * count_q;
	assign din      = (cmd.op == OP_DSTEP) ? num_q[ACC_W-1] : 1'b0;
	assign rem2     = {rem_q[ACC_W-2:0], din};
	assign dge      = rem2 >= m2_q;
	assign x_val    = quo_q - (64'd1 << 32);
	assign xm_prod  = x_q[50:0] * XM_SCALE;
	assign rt_sum   = {1'b0, r_q} + {1'b0, bit_q};
	assign rt_ge    = {1'b0, y_q} >= rt_sum;
	assign ld_mag   = mag64(ld_s);

	always_comb begin
		ld_s = prev2_q;
		ld_c = cos_q;
		if (cmd.op == OP_LD_PC) begin
			ld_s = prev_q;
		end else if (cmd.op == OP_LD_P2S) begin
			ld_c = sin_q;
		end
	end

	always_comb begin
		sts.full      = count_q == CNT_W'(MAX_SAMPLES);
		sts.last      = last_q;
		sts.cnt_lt8   = count_q < CNT_W'(MIN_SAMPLES);
		sts.e_zero    = energy_q == '0;
		sts.mag_zero  = (ar_q | ai_q) == '0;
		sts.norm_done = (ar_q[ACC_W-1:31] | ai_q[ACC_W-1:31]) == '0;
		sts.en_ovf    = en_q[PR_W-1:ACC_W] != '0;
		sts.ex_neg    = ex_q[EX_W-1];
		sts.ex_zero   = ex_q == '0;
		sts.q_small   = quo_q <= (64'd1 << 32);
		sts.x_big     = x_val > X_LIMIT;
	end

	// configuration and record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RESET;
			sin_q    <= SIN_RESET;
			prev_q   <= '0;
			prev2_q  <= '0;
			energy_q <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_COS: cos_q <= cfg_data;
					REG_SIN: sin_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_SUPD) begin
				prev2_q  <= prev_q;
				prev_q   <= s_sat;
				energy_q <= energy_q + EN_W'(sq_q);
				count_q  <= count_q + 1'b1;
			end else if (cmd.op == OP_OUT) begin
				prev_q   <= '0;
				prev2_q  <= '0;
				energy_q <= '0;
				count_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_TAKE: begin
				xs_q   <= signed'(sample);
				last_q <= last_sample;
			end
			OP_LD_PC, OP_LD_P2C, OP_LD_P2S: begin
				ma_q   <= ld_mag[61:0];
				mb_q   <= ld_c[COEF_W-1] ? -ld_c : ld_c;
				neg_q  <= ld_s[ACC_W-1] ^ ld_c[COEF_W-1];
				sh29_q <= cmd.op == OP_LD_PC;
				sq_q   <= sq_prod;
			end
			OP_MLO:  plo_q  <= plo_prod;
			OP_MHI:  phi_q  <= phi_prod;
			OP_MSAT: mres_q <= neg_q ? -ACC_W'(p_cap) : ACC_W'(p_cap);
			OP_FRE:  ar_q   <= re_sum[64] ? ACC_W'(-re_sum) : ACC_W'(re_sum);
			OP_FIM: begin
				ai_q <= mag64(mres_q);
				ex_q <= EX_W'(EX_INIT);
			end
			OP_STAT: begin
				thd_q <= '0;
				if (sts.cnt_lt8) stat_q <= STAT_SHORT;
				else if (sts.e_zero) stat_q <= STAT_ZERO;
				else stat_q <= STAT_NOFUND;
			end
			OP_NORM: begin
				if (!sts.norm_done) begin
					ar_q <= ar_q >> 1;
					ai_q <= ai_q >> 1;
					ex_q <= ex_q - EX_W'(2);
				end
			end
			OP_SQA: sqa_q <= ACC_W'(sqa_prod);
			OP_SQB: begin
				m2_q   <= sqa_q + ACC_W'(sqb_prod);
				e_q    <= energy_q;
				stat_q <= STAT_OK;
				thd_q  <= '0;
			end
			OP_EN: en_q <= en_prod;
			OP_ENADJ: begin
				if (sts.en_ovf) begin
					e_q  <= e_q >> 1;
					ex_q <= ex_q + EX_W'(1);
				end
			end
			OP_DINIT: begin
				num_q <= en_q[ACC_W-1:0];
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DSTEP: begin
				rem_q <= dge ? rem2 - m2_q : rem2;
				quo_q <= {quo_q[ACC_W-2:0], dge};
				num_q <= num_q << 1;
			end
			OP_DEXT: begin
				if (quo_q >= (64'd1 << 61)) begin
					quo_q <= 64'd1 << 62;
					ex_q  <= '0;
				end else begin
					rem_q <= dge ? rem2 - m2_q : rem2;
					quo_q <= {quo_q[ACC_W-2:0], dge};
					ex_q  <= ex_q - EX_W'(1);
				end
			end
			OP_DSHR: begin
				quo_q <= quo_q >> 1;
				ex_q  <= ex_q + EX_W'(1);
			end
			OP_X: begin
				x_q   <= x_val;
				thd_q <= (!sts.q_small && sts.x_big) ? '1 : '0;
			end
			OP_XM: begin
				y_q   <= xm_prod;
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			OP_SQRT: begin
				if (rt_ge) begin
					y_q <= y_q - rt_sum[ACC_W-1:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_THD: thd_q <= r_q[31:8];
			OP_OUT: begin
				thd_out_q  <= thd_q;
				stat_out_q <= stat_q;
			end
			default: ;
		endcase
	end

	assign thd_pct = thd_out_q;
	assign status  = stat_out_q;

endmodule

// ===== sv/gte_ctrl.sv =====
// Controller: sequences the per-sample recurrence and the end-of-record
// evaluation, and owns the stream handshakes. Uses gte_pkg.
module gte_ctrl import gte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  gte_sts_t sts,
	output gte_cmd_t cmd
);

	gte_state_t state_q, state_d;
	gte_phase_t phase_q, phase_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic out_valid_q, load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SAMPLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			step_q      <= step_d;
			out_valid_q <= load_out | (out_valid_q & ~m_tready);
		end
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		step_d   = step_q;
		cmd.op   = OP_NONE;
		s_tready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_TAKE;
					state_d = ST_SLD;
				end
			end
			ST_SLD: begin
				cmd.op  = OP_LD_PC;
				phase_d = PH_SAMPLE;
				if (sts.full) state_d = sts.last ? ST_FCHK : ST_IDLE;
				else state_d = ST_MLO;
			end
			ST_MLO: begin
				cmd.op  = OP_MLO;
				state_d = ST_MHI;
			end
			ST_MHI: begin
				cmd.op  = OP_MHI;
				state_d = ST_MSAT;
			end
			ST_MSAT: begin
				cmd.op = OP_MSAT;
				unique case (phase_q)
					PH_SAMPLE: state_d = ST_SUPD;
					PH_RE:     state_d = ST_FRE;
					PH_IM:     state_d = ST_FIM;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_SUPD: begin
				cmd.op  = OP_SUPD;
				state_d = sts.last ? ST_FCHK : ST_IDLE;
			end
			ST_FCHK: state_d = (sts.cnt_lt8 || sts.e_zero) ? ST_FSTAT : ST_FLDC;
			ST_FLDC: begin
				cmd.op  = OP_LD_P2C;
				phase_d = PH_RE;
				state_d = ST_MLO;
			end
			ST_FRE: begin
				cmd.op  = OP_FRE;
				state_d = ST_FLDS;
			end
			ST_FLDS: begin
				cmd.op  = OP_LD_P2S;
				phase_d = PH_IM;
				state_d = ST_MLO;
			end
			ST_FIM: begin
				cmd.op  = OP_FIM;
				state_d = ST_FZ;
			end
			ST_FZ: state_d = sts.mag_zero ? ST_FSTAT : ST_NORM;
			ST_FSTAT: begin
				cmd.op  = OP_STAT;
				state_d = ST_DONE;
			end
			ST_NORM: begin
				if (sts.norm_done) state_d = ST_SQA;
				else cmd.op = OP_NORM;
			end
			ST_SQA: begin
				cmd.op  = OP_SQA;
				state_d = ST_SQB;
			end
			ST_SQB: begin
				cmd.op  = OP_SQB;
				state_d = ST_EN;
			end
			ST_EN: begin
				cmd.op  = OP_EN;
				state_d = ST_ENADJ;
			end
			ST_ENADJ: begin
				cmd.op  = OP_ENADJ;
				state_d = sts.en_ovf ? ST_EN : ST_DINIT;
			end
			ST_DINIT: begin
				cmd.op  = OP_DINIT;
				step_d  = STEP_W'(DIV_STEPS - 1);
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DSTEP;
				if (step_q == '0) state_d = ST_DEXT;
				else step_d = step_q - 1'b1;
			end
			ST_DEXT: begin
				if (sts.ex_zero) state_d = ST_XCHK;
				else if (sts.ex_neg) cmd.op = OP_DSHR;
				else cmd.op = OP_DEXT;
			end
			ST_XCHK: begin
				cmd.op  = OP_X;
				state_d = (sts.q_small || sts.x_big) ? ST_DONE : ST_XM;
			end
			ST_XM: begin
				cmd.op  = OP_XM;
				step_d  = STEP_W'(SQRT_STEPS - 1);
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT;
				if (step_q == '0) state_d = ST_THD;
				else step_d = step_q - 1'b1;
			end
			ST_THD: begin
				cmd.op  = OP_THD;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.op   = OP_OUT;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== sv/goertzel_thd_estimator.sv =====
// Goertzel single-bin THD estimator, top level. Uses gte_pkg, gte_ctrl, gte_datapath.
// Intake: each sample request passes accept, operand load, two 32x32 partial
// products, saturate and a state update through the shared multiplier before
// the next is accepted. End of record: a short or silent record yields only a
// status; the full path runs the 64-step divider, up to 47 extension steps, up
// to 32 normalise steps and the 32-step square root; a held result stalls intake.
// Reset: record state cleared, cos_coef = 1.0, sin_coef = 0, no result pending.
module goertzel_thd_estimator import gte_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // sample
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [THD_W-1:0]     m_tdata,   // thd_pct
	output logic [STAT_W-1:0]    m_tuser,   // status
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [COEF_W-1:0]    cfg_data
);

	gte_cmd_t cmd;
	gte_sts_t sts;

	gte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gte_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.sample      (s_tdata[SAMPLE_BITS-1:0]),
		.last_sample (s_tlast),
		.thd_pct     (m_tdata),
		.status      (m_tuser)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for goertzel_thd_estimator: streams sample records, models the
// Goertzel recurrence and THD arithmetic in fixed point, and compares each result.
// Depends on gte_pkg and the goertzel_thd_estimator RTL.
module testbench import gte_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	typedef bit [63:0] u64;
	typedef struct {
		logic [THD_W-1:0] thd;
		gte_stat_t        st;
	} thd_res_t;
	typedef struct {
		logic [15:0]      smp;
		bit               lst;
		bit               known;
		logic [THD_W-1:0] thd;
		gte_stat_t        st;
	} dir_row_t;

	localparam longint SAT_LIM = longint'(1) << 61;
	localparam int     REC_MAX = 4096;
	localparam int     LIMIT   = 2000000;
	localparam int     SETTLE  = 260;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;   // sample
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [THD_W-1:0]     m_tdata;        // thd_pct
	logic [STAT_W-1:0]    m_tuser;        // status
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = REG_COS;
	logic [COEF_W-1:0]    cfg_data = '0;

	goertzel_thd_estimator i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bin coefficients and record state
	longint   bin_cos, bin_sin, g_s1, g_s2;
	u64       energy;
	int unsigned n_taken;
	thd_res_t thd_q[$];
	int       errs = 0;
	int       cycles = 0;
	int       n_sent = 0;
	bit       quiet = 0;
	bit       hold_req = 0;
	int       hold_cnt = 0;
	int       rgap = 0;

	function automatic u64 absv(longint v);
		return v < 0 ? u64'(-v) : u64'(v);
	endfunction

	function automatic longint coef_mul(longint s, longint c, int sh);
		u64 a, b, p;
		longint r;
		a = absv(s);
		b = absv(c);
		p = (((a >> 32) * b) << (32 - sh)) + (((a & 64'hFFFF_FFFF) * b) >> sh);
		if (p > u64'(SAT_LIM)) p = u64'(SAT_LIM);
		r = longint'(p);
		return ((s < 0) != (c < 0)) ? -r : r;
	endfunction

	function automatic u64 int_sqrt(u64 y);
		u64 r, bt;
		r = 0;
		bt = u64'(1) << 62;
		while (bt > y) bt >>= 2;
		while (bt != 0) begin
			if (y >= r + bt) begin
				y -= r + bt;
				r = (r >> 1) + bt;
			end else r >>= 1;
			bt >>= 2;
		end
		return r;
	endfunction

	function automatic u64 ratio_q32(u64 n, u64 d, int ex);
		u64 q, r, bt;
		if (ex < 0) begin
			if (ex <= -64) return 0;
			return (n / d) >> (-ex);
		end
		q = n / d;
		r = n % d;
		for (int i = 0; i < ex; i++) begin
			if (q >= (u64'(1) << 61)) return u64'(1) << 62;
			bt = u64'(r[63] | ((r << 1) >= d));
			r = (r << 1) - (bt != 0 ? d : 0);
			q = (q << 1) | bt;
		end
		return q;
	endfunction

	function automatic thd_res_t thd_close();
		thd_res_t res;
		longint re, im;
		u64 ar, ai, m2, e, n, q, x;
		int sh, ex;
		res.thd = '0;
		res.st = STAT_OK;
		sh = 0;
		if (n_taken < MIN_SAMPLES) res.st = STAT_SHORT;
		else if (energy == 0) res.st = STAT_ZERO;
		else begin
			re = g_s1 - coef_mul(g_s2, bin_cos, 30);
			im = coef_mul(g_s2, bin_sin, 30);
			ar = absv(re);
			ai = absv(im);
			if ((ar | ai) == 0) res.st = STAT_NOFUND;
			else begin
				while ((ar | ai) >= (u64'(1) << 31)) begin
					ar >>= 1;
					ai >>= 1;
					sh++;
				end
				m2 = ar * ar + ai * ai;
				ex = 32 + 2 * GFRAC - 2 * sh - 1;
				n = n_taken;
				e = energy;
				while (e > 64'hFFFF_FFFF_FFFF_FFFF / n) begin
					e >>= 1;
					ex++;
				end
				q = ratio_q32(e * n, m2, ex);
				if (q > (u64'(1) << 32)) begin
					x = q - (u64'(1) << 32);
					if (x > 64'hFFFF_FFFF_FFFF_FFFF / 10000) res.thd = '1;
					else res.thd = THD_W'(int_sqrt(x * 10000) >> 8);
				end
			end
		end
		g_s1 = 0;
		g_s2 = 0;
		energy = 0;
		n_taken = 0;
		return res;
	endfunction

	// returns 1 when the request closes a record
	function automatic bit thd_take(logic [15:0] smp, bit lst, output thd_res_t res);
		longint xs, s;
		if (n_taken < REC_MAX) begin
			xs = longint'($signed(smp));
			s = xs * 256 + coef_mul(g_s1, bin_cos, 29) - g_s2;
			g_s2 = g_s1;
			g_s1 = s > SAT_LIM ? SAT_LIM : (s < -SAT_LIM ? -SAT_LIM : s);
			energy += u64'(xs * xs);
			n_taken++;
		end
		if (lst) res = thd_close();
		return lst;
	endfunction

	task automatic send(logic [15:0] smp, bit lst, bit known = 0,
			logic [THD_W-1:0] thd = '0, gte_stat_t st = STAT_OK);
		int gap;
		thd_res_t res;
		gap = quiet ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(8, 40)
			: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0));
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = smp;
		s_tlast = lst;
		do @(posedge clk); while (!s_tready);
		if (thd_take(smp, lst, res)) begin
			if (known) begin
				res.thd = thd;
				res.st = st;
			end
			thd_q = {thd_q, res};
		end
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		wait (thd_q.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_COS) bin_cos = longint'($signed(v));
		else bin_sin = longint'($signed(v));
	endtask

	// kind 0 noise, 1 silence, 2 tone with third harmonic at angle w
	task automatic send_record(int len, int kind, real w);
		real a1, a3, ph, v;
		logic [15:0] smp;
		a1 = $urandom_range(100, 30000);
		a3 = a1 * $urandom_range(0, 40) / 100.0;
		ph = $urandom_range(0, 628) / 100.0;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: smp = 16'($urandom);
				1: smp = '0;
				default: begin
					v = a1 * $cos(w * i + ph) + a3 * $cos(3.0 * w * i)
						+ $urandom_range(0, 200) - 100.0;
					if (v > 32767.0) v = 32767.0;
					if (v < -32768.0) v = -32768.0;
					smp = 16'($rtoi(v));
				end
			endcase
			send(smp, i == len - 1);
		end
	endtask

	dir_row_t dir_tab[19] = '{
		'{16'h7FFF, 0, 0, '0, STAT_OK},
		'{16'h8000, 0, 0, '0, STAT_OK},
		'{16'h0001, 1, 1, '0, STAT_SHORT},
		'{16'h0000, 0, 0, '0, STAT_OK},
		'{16'h0000, 0, 0, '0, STAT_OK},
		'{16'h0000, 0, 0, '0, STAT_OK},
		'{16'h0000, 0, 0, '0, STAT_OK},
		'{16'h0000, 0, 0, '0, STAT_OK},
		'{16'h0000, 0, 0, '0, STAT_OK},
		'{16'h0000, 0, 0, '0, STAT_OK},
		'{16'h0000, 1, 1, '0, STAT_ZERO},
		'{16'h7FFF, 0, 0, '0, STAT_OK},
		'{16'h8000, 0, 0, '0, STAT_OK},
		'{16'h7FFF, 0, 0, '0, STAT_OK},
		'{16'h8000, 0, 0, '0, STAT_OK},
		'{16'h7FFF, 0, 0, '0, STAT_OK},
		'{16'h8000, 0, 0, '0, STAT_OK},
		'{16'h7FFF, 0, 0, '0, STAT_OK},
		'{16'h8000, 1, 0, '0, STAT_OK}
	};

	// result side: random back-pressure plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 600;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			m_tready <= 1'b0;
			hold_cnt--;
		end else if (rgap > 0) begin
			m_tready <= 1'b0;
			rgap--;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				rgap = $urandom_range(0, 7) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		thd_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (thd_q.size() == 0) begin
				$error("unexpected result thd_pct=%h status=%0d", m_tdata, m_tuser);
				errs++;
			end else begin
				want = thd_q.pop_front();
				if (m_tdata !== want.thd) begin
					$error("thd_pct: expected %h, got %h", want.thd, m_tdata);
					errs++;
				end
				if (m_tuser !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, m_tuser);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("goertzel_thd_estimator test failed");
			$finish;
		end
	end

	initial begin
		real w;
		logic [31:0] cfg_cos[6], cfg_sin[6];
		bin_cos = longint'(1) << 30;
		bin_sin = 0;
		g_s1 = 0;
		g_s2 = 0;
		energy = 0;
		n_taken = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send(dir_tab[i].smp, dir_tab[i].lst, dir_tab[i].known, dir_tab[i].thd, dir_tab[i].st);
		drain();

		w = 2.0 * 3.14159265358979 / 16.0;
		cfg_cos = '{32'h4000_0000, 32'hC000_0000, 32'h0000_0000,
			32'($rtoi($cos(w) * 1073741824.0)), 32'h7FFF_FFFF, $urandom};
		cfg_sin = '{32'h0000_0000, 32'h0000_0000, 32'h4000_0000,
			32'($rtoi($sin(w) * 1073741824.0)), 32'h8000_0000, $urandom};
		for (int p = 0; p < 6; p++) begin
			reg_write(REG_COS, cfg_cos[p]);
			reg_write(REG_SIN, cfg_sin[p]);
			quiet = (p == 2);
			if (p == 1) hold_req = 1;
			for (int k = 0; k < 250; ) begin
				int len, kind;
				kind = $urandom_range(0, 9) < 6 ? 2 : ($urandom_range(0, 9) == 0 ? 1 : 0);
				len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 7) : $urandom_range(8, 40);
				send_record(len, kind, p == 1 ? 3.14159265358979 : w);
				k += len;
			end
			drain();
		end

		if (errs == 0) $display("goertzel_thd_estimator test passed");
		else $display("goertzel_thd_estimator test failed");
		$finish;
	end
endmodule
